>>> hdl/min_tracking_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the min tracking queue
// Concurrent checks on clk with rst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_QUEUE_MACROS_SVH
`define MIN_TRACKING_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// A condition that holds at every clock edge out of reset.
`define MTQ_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequent that holds in the same cycle as its antecedent.
`define MTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that holds in the cycle after its antecedent.
`define MTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MTQ_ASSERT(lbl, expr, msg)
`define MTQ_ASSERT_IMP(lbl, ante, cons, msg)
`define MTQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/mtq_pkg.sv
// ----------------------------------------------------------------------------
// mtq_pkg
// Types and constants shared by the min tracking queue and its cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package mtq_pkg;

    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    localparam logic signed [VAL_W-1:0] EMPTY_MIN = 32'sh7FFF_FFFF;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } op_err_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } mtq_state_t;

    typedef struct packed {
        logic                     cmd;
        logic signed [VAL_W-1:0]  push_value;
    } mtq_cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  popped_value;
        logic signed [VAL_W-1:0]  current_min;
        logic                     is_empty;
        op_err_t                  op_error;
    } mtq_res_t;

    // Broadcast to every cell of the minimum chain.
    typedef struct packed {
        logic                     push;
        logic                     shift;
        logic signed [VAL_W-1:0]  value;
    } mtq_chain_ctrl_t;

    // Head of the chain, as seen by the queue control.
    typedef struct packed {
        logic                     front_valid;
        logic signed [VAL_W-1:0]  front_value;
        logic                     second_valid;
        logic signed [VAL_W-1:0]  second_value;
    } mtq_chain_head_t;

endpackage

`default_nettype wire

>>> hdl/min_tracking_queue.sv
// ----------------------------------------------------------------------------
// min_tracking_queue
// FIFO of signed 32-bit values that reports the minimum of its contents.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Carries
//  -------   ------------------------------   -----------------------------
//  command   cmd_valid, cmd_stall, cmd_data   push of a value or pop
//  result    res_valid, res_stall, res_data   popped value, minimum, status
//
// Each operation is a registered read of the ring memory, followed by the
// update of the counters and the minimum chain.
// Reset clears the counters and the chain valid bits at once; there is no
// clearing pass over the ring memory.
// A result waiting in the output register holds the following operation in
// its update cycle until that result has been transferred.
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_tracking_queue_macros.svh"

module min_tracking_queue
    import mtq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire mtq_cmd_t  cmd_data,
    output logic           res_valid,
    input  wire logic      res_stall,
    output mtq_res_t       res_data
);

    mtq_state_t               state_reg;
    mtq_state_t               state_next;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [IDX_W-1:0]         oldest_reg;
    logic [IDX_W-1:0]         oldest_next;
    logic [IDX_W-1:0]         free_reg;
    logic [IDX_W-1:0]         free_next;

    mtq_cmd_t                 op_reg;
    logic signed [VAL_W-1:0]  rd_data_reg;
    logic signed [VAL_W-1:0]  value_store [DEPTH];

    logic                     res_valid_reg;
    logic                     res_valid_next;
    mtq_res_t                 res_data_reg;
    mtq_res_t                 res_data_next;

    logic                     accept;
    logic                     commit;
    logic                     slot_free;
    logic                     is_pop;
    logic                     full;
    logic                     empty;
    logic                     do_push;
    logic                     do_pop;
    logic                     pop_hits_front;
    logic signed [VAL_W-1:0]  push_val;
    logic signed [VAL_W-1:0]  min_after;

    mtq_chain_ctrl_t          chain_ctrl;
    mtq_chain_head_t          chain_head;

    // ------------------------------------------------------------------
    // Control state machine
    // ------------------------------------------------------------------
    assign accept    = cmd_valid && !cmd_stall;
    assign slot_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_stall = 1'b1;
        commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
            end
            ST_EXEC:
            begin
                commit = slot_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            oldest_reg    <= '0;
            free_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            free_reg      <= free_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Ring memory: the oldest entry is read as the operation is taken in
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= cmd_data;
            rd_data_reg <= value_store[oldest_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && do_push)
        begin
            value_store[free_reg] <= push_val;
        end
    end

    // ------------------------------------------------------------------
    // Operation update
    // ------------------------------------------------------------------
    assign push_val = op_reg.push_value;
    assign is_pop   = (op_reg.cmd == CMD_POP);
    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = !is_pop && !full;
    assign do_pop   = is_pop && !empty;

    // The front cell leaves only when the value popped is that minimum.
    assign pop_hits_front = do_pop && chain_head.front_valid
                            && (rd_data_reg == chain_head.front_value);

    assign chain_ctrl.push  = commit && do_push;
    assign chain_ctrl.shift = commit && pop_hits_front;
    assign chain_ctrl.value = push_val;

    always_comb
    begin
        if (do_push)
        begin
            if (!chain_head.front_valid || (chain_head.front_value > push_val))
            begin
                min_after = push_val;
            end
            else
            begin
                min_after = chain_head.front_value;
            end
        end
        else if (pop_hits_front)
        begin
            min_after = chain_head.second_valid ? chain_head.second_value : EMPTY_MIN;
        end
        else
        begin
            min_after = chain_head.front_valid ? chain_head.front_value : EMPTY_MIN;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        oldest_next = oldest_reg;
        free_next   = free_reg;
        if (commit && do_push)
        begin
            count_next = count_reg + CNT_W'(1);
            free_next  = (free_reg == LAST_IDX) ? '0 : free_reg + IDX_W'(1);
        end
        else if (commit && do_pop)
        begin
            count_next  = count_reg - CNT_W'(1);
            oldest_next = (oldest_reg == LAST_IDX) ? '0 : oldest_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        res_data_next.popped_value = do_pop ? rd_data_reg : '0;
        res_data_next.current_min  = min_after;
        if (do_pop)
        begin
            res_data_next.is_empty = (count_reg == CNT_W'(1));
        end
        else if (do_push)
        begin
            res_data_next.is_empty = 1'b0;
        end
        else
        begin
            res_data_next.is_empty = empty;
        end
        if (!is_pop && full)
        begin
            res_data_next.op_error = ERR_FULL;
        end
        else if (is_pop && empty)
        begin
            res_data_next.op_error = ERR_EMPTY;
        end
        else
        begin
            res_data_next.op_error = ERR_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    mtq_min_chain u_min_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (chain_ctrl),
        .head  (chain_head)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MTQ_ASSERT(a_count_bound, count_reg <= DEPTH_CNT, "entry count exceeds depth")
    `MTQ_ASSERT(a_chain_tracks_fill, (count_reg == '0) == !chain_head.front_valid, "minimum chain out of step with fill")
    `MTQ_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == ST_EXEC, "accepted command did not start")
    `MTQ_ASSERT_IMP(a_full_flag, commit && !is_pop && full, count_next == DEPTH_CNT, "dropped push changed the fill")

endmodule

`default_nettype wire

>>> hdl/mtq_cell.sv
// ----------------------------------------------------------------------------
// mtq_cell
// One cell of the minimum chain: holds one candidate minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module mtq_cell
    import mtq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mtq_chain_ctrl_t          ctrl,
    input  wire logic                     prev_keep,
    input  wire logic                     next_valid,
    input  wire logic signed [VAL_W-1:0]  next_value,
    output logic                          valid,
    output logic signed [VAL_W-1:0]       value,
    output logic                          keep
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [VAL_W-1:0]  value_reg;
    logic signed [VAL_W-1:0]  value_next;

    // A cell survives a push only if its value does not exceed the new one.
    assign keep = valid_reg && (value_reg <= ctrl.value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift)
        begin
            valid_next = next_valid;
            value_next = next_value;
        end
        else if (ctrl.push && !keep)
        begin
            // The first cell that is not kept takes the new value; the rest empty.
            if (prev_keep)
            begin
                valid_next = 1'b1;
                value_next = ctrl.value;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

>>> hdl/mtq_min_chain.sv
// ----------------------------------------------------------------------------
// mtq_min_chain
// Row of cells holding the non-decreasing run of candidate minima.
// ----------------------------------------------------------------------------
`default_nettype none

module mtq_min_chain
    import mtq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mtq_chain_ctrl_t  ctrl,
    output mtq_chain_head_t       head
);

    logic                     cell_valid [DEPTH];
    logic signed [VAL_W-1:0]  cell_value [DEPTH];
    logic                     cell_keep  [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                     prev_keep;
            logic                     next_valid;
            logic signed [VAL_W-1:0]  next_value;

            if (i == 0)
            begin : g_first
                assign prev_keep = 1'b1;
            end
            else
            begin : g_inner
                assign prev_keep = cell_keep[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign next_valid = 1'b0;
                assign next_value = '0;
            end
            else
            begin : g_body
                assign next_valid = cell_valid[i+1];
                assign next_value = cell_value[i+1];
            end

            mtq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_keep  (prev_keep),
                .next_valid (next_valid),
                .next_value (next_value),
                .valid      (cell_valid[i]),
                .value      (cell_value[i]),
                .keep       (cell_keep[i])
            );
        end
    endgenerate

    assign head.front_valid  = cell_valid[0];
    assign head.front_value  = cell_value[0];
    assign head.second_valid = cell_valid[1];
    assign head.second_value = cell_value[1];

endmodule

`default_nettype wire
